[hdl/tlbpt_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the tlb translate block
// no dependencies

package tlbpt_pkg;

    localparam int VA_W    = 28;
    localparam int PA_W    = 16;
    localparam int AGE_W   = 32;
    localparam int STAMP_W = 64;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOOK  = 5'b00010,
        ST_FSCAN = 5'b00100,
        ST_PLACE = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             gt;
    } t_age_cmp;

endpackage

[hdl/tlbpt_age_unit.sv]
`timescale 1ns / 1ps
// shared age unit: saturated age from a load stamp, compared with the running best
// depends on tlbpt_pkg

module tlbpt_age_unit (
    input  logic [tlbpt_pkg::STAMP_W-1:0] i_now,
    input  logic [tlbpt_pkg::STAMP_W-1:0] i_stamp,
    input  logic [tlbpt_pkg::AGE_W-1:0]   i_best,
    output tlbpt_pkg::t_age_cmp           o_cmp
);

    logic [tlbpt_pkg::STAMP_W-1:0] diff;

    always_comb begin
        diff = i_now - i_stamp;
        if (|diff[tlbpt_pkg::STAMP_W-1:tlbpt_pkg::AGE_W]) begin
            o_cmp.age = '1;
        end else begin
            o_cmp.age = diff[tlbpt_pkg::AGE_W-1:0];
        end
        o_cmp.gt = (o_cmp.age > i_best);
    end

endmodule

[hdl/tlb_page_table_translate_lru.sv]
`timescale 1ns / 1ps
// tlb with lru replacement and demand paging, serial scans over tag memories
// depends on tlbpt_pkg and tlbpt_age_unit
// a hit scans the tlb tags only; a miss also scans the frame table and then the tlb again to place the entry
// one item at a time: a new address is accepted only in the idle state, and the scans run
// one entry per cycle through a single read port and the shared age unit
// reset: control state, valid bits, frame fill count and access counter clear at once

module tlb_page_table_translate_lru #(
    parameter int TLB_ENTRIES = 64,
    parameter int FRAME_COUNT = 256,
    parameter int OFFSET_BITS = 8,
    parameter int PAGE_BITS   = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // virtual_address
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // physical_address
    output logic [1:0]  o_m_tuser    // tlb_hit, page_fault
);

    localparam int TW     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FW     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int MAXN   = (TLB_ENTRIES > FRAME_COUNT) ? TLB_ENTRIES : FRAME_COUNT;
    localparam int CNT_W  = $clog2(MAXN + 1);
    localparam int FILL_W = $clog2(FRAME_COUNT + 1);

    tlbpt_pkg::t_state r_state;

    logic [PAGE_BITS-1:0]          m_tpage  [TLB_ENTRIES];
    logic [FW-1:0]                 m_tframe [TLB_ENTRIES];
    logic [tlbpt_pkg::STAMP_W-1:0] m_tstamp [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]          m_fowner [FRAME_COUNT];
    logic [tlbpt_pkg::STAMP_W-1:0] m_fstamp [FRAME_COUNT];

    logic [PAGE_BITS-1:0]          r_tpage_rd;
    logic [FW-1:0]                 r_tframe_rd;
    logic [tlbpt_pkg::STAMP_W-1:0] r_tstamp_rd;
    logic [PAGE_BITS-1:0]          r_fowner_rd;
    logic [tlbpt_pkg::STAMP_W-1:0] r_fstamp_rd;

    logic [TLB_ENTRIES-1:0]        r_tvalid;
    logic [FILL_W-1:0]             r_fill;
    logic [tlbpt_pkg::STAMP_W-1:0] r_now;

    logic [CNT_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_pidx;
    logic                          r_pv;

    logic [PAGE_BITS-1:0]          r_page;
    logic [OFFSET_BITS-1:0]        r_offset;
    logic [FW-1:0]                 r_frame;
    logic                          r_hit;
    logic                          r_fault;
    logic                          r_evict;
    logic                          r_fmatch;
    logic [FW-1:0]                 r_fmatch_idx;
    logic [tlbpt_pkg::AGE_W-1:0]   r_best;
    logic [CNT_W-1:0]              r_vict;
    logic                          r_free;
    logic [TW-1:0]                 r_free_idx;

    logic                          r_out_vld;
    logic [15:0]                   r_out_pa;
    logic [1:0]                    r_out_user;

    tlbpt_pkg::t_age_cmp           age_cmp;
    logic [tlbpt_pkg::STAMP_W-1:0] age_stamp;
    logic [63:0]                   va_ext;
    logic [63:0]                   pa_ext;
    logic                          scan_n_hit;
    logic                          proc_last;
    logic [CNT_W-1:0]              scan_n;
    logic                          out_free;
    logic                          have_free_frame;
    logic [TW-1:0]                 pe;
    logic [FW-1:0]                 pf;
    logic                          t_kill;
    logic                          f_valid;

    assign age_stamp = (r_state == tlbpt_pkg::ST_FSCAN) ? r_fstamp_rd : r_tstamp_rd;

    tlbpt_age_unit u_age (
        .i_now   (r_now),
        .i_stamp (age_stamp),
        .i_best  (r_best),
        .o_cmp   (age_cmp)
    );

    always_comb begin
        va_ext          = 64'(i_s_tdata[tlbpt_pkg::VA_W-1:0]);
        scan_n          = (r_state == tlbpt_pkg::ST_FSCAN) ? CNT_W'(FRAME_COUNT)
                                                           : CNT_W'(TLB_ENTRIES);
        scan_n_hit      = (r_idx < scan_n);
        proc_last       = r_pv && (r_pidx == scan_n - CNT_W'(1));
        out_free        = !r_out_vld || i_m_tready;
        have_free_frame = (r_fill < FILL_W'(FRAME_COUNT));
        pe              = r_pidx[TW-1:0];
        pf              = r_pidx[FW-1:0];
        t_kill          = r_evict && r_tvalid[pe] && (r_tframe_rd == r_frame);
        f_valid         = (32'(r_pidx) < 32'(r_fill));
        pa_ext          = (64'(r_frame) << OFFSET_BITS) | 64'(r_offset);
    end

    // memory reads, one address per cycle
    always_ff @(posedge i_clk) begin
        r_tpage_rd  <= m_tpage[r_idx[TW-1:0]];
        r_tframe_rd <= m_tframe[r_idx[TW-1:0]];
        r_tstamp_rd <= m_tstamp[r_idx[TW-1:0]];
        r_fowner_rd <= m_fowner[r_idx[FW-1:0]];
        r_fstamp_rd <= m_fstamp[r_idx[FW-1:0]];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == tlbpt_pkg::ST_LOOK && r_pv && r_tvalid[pe]
                && r_tpage_rd == r_page) begin
            m_tstamp[pe] <= r_now;
        end
        if (r_state == tlbpt_pkg::ST_FIN && out_free) begin
            if (!r_hit) begin
                m_tpage[r_free_idx]  <= r_page;
                m_tframe[r_free_idx] <= r_frame;
                m_tstamp[r_free_idx] <= r_now;
            end
            if (r_fault) begin
                m_fowner[r_frame] <= r_page;
                m_fstamp[r_frame] <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tlbpt_pkg::ST_IDLE;
            r_tvalid  <= '0;
            r_fill    <= '0;
            r_now     <= '0;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state != tlbpt_pkg::ST_IDLE && r_state != tlbpt_pkg::ST_FIN) begin
                if (scan_n_hit) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                r_pv   <= scan_n_hit;
                r_pidx <= r_idx;
            end
            unique case (r_state)
                tlbpt_pkg::ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_page   <= PAGE_BITS'(va_ext >> OFFSET_BITS);
                        r_offset <= OFFSET_BITS'(va_ext);
                        r_hit    <= 1'b0;
                        r_fault  <= 1'b0;
                        r_evict  <= 1'b0;
                        r_idx    <= '0;
                        r_pv     <= 1'b0;
                        r_state  <= tlbpt_pkg::ST_LOOK;
                    end
                end
                tlbpt_pkg::ST_LOOK: begin
                    if (r_pv && r_tvalid[pe] && r_tpage_rd == r_page) begin
                        r_hit   <= 1'b1;
                        r_frame <= r_tframe_rd;
                    end
                    if (proc_last) begin
                        r_idx    <= '0;
                        r_pv     <= 1'b0;
                        r_best   <= '0;
                        r_vict   <= '0;
                        r_fmatch <= 1'b0;
                        if (r_hit || (r_tvalid[pe] && r_tpage_rd == r_page)) begin
                            r_state <= tlbpt_pkg::ST_FIN;
                        end else begin
                            r_state <= tlbpt_pkg::ST_FSCAN;
                        end
                    end
                end
                tlbpt_pkg::ST_FSCAN: begin
                    if (r_pv) begin
                        if (f_valid && r_fowner_rd == r_page) begin
                            r_fmatch     <= 1'b1;
                            r_fmatch_idx <= pf;
                        end
                        if (age_cmp.gt) begin
                            r_best <= age_cmp.age;
                            r_vict <= r_pidx;
                        end
                    end
                    if (proc_last) begin
                        r_idx  <= '0;
                        r_pv   <= 1'b0;
                        r_best <= '0;
                        r_vict <= '0;
                        r_free <= 1'b0;
                        if (r_fmatch || (f_valid && r_fowner_rd == r_page)) begin
                            r_frame <= r_fmatch ? r_fmatch_idx : pf;
                        end else begin
                            r_fault <= 1'b1;
                            if (have_free_frame) begin
                                r_frame <= r_fill[FW-1:0];
                            end else begin
                                r_evict <= 1'b1;
                                r_frame <= age_cmp.gt ? pf : r_vict[FW-1:0];
                            end
                        end
                        r_state <= tlbpt_pkg::ST_PLACE;
                    end
                end
                tlbpt_pkg::ST_PLACE: begin
                    if (r_pv) begin
                        if (t_kill) begin
                            r_tvalid[pe] <= 1'b0;
                        end
                        if ((!r_tvalid[pe] || t_kill) && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= pe;
                        end
                        if (age_cmp.gt) begin
                            r_best <= age_cmp.age;
                            r_vict <= r_pidx;
                        end
                    end
                    if (proc_last) begin
                        r_idx <= '0;
                        r_pv  <= 1'b0;
                        if (!r_free && !(!r_tvalid[pe] || t_kill)) begin
                            r_free_idx <= age_cmp.gt ? pe : r_vict[TW-1:0];
                        end
                        r_state <= tlbpt_pkg::ST_FIN;
                    end
                end
                tlbpt_pkg::ST_FIN: begin
                    if (out_free) begin
                        if (!r_hit) begin
                            r_tvalid[r_free_idx] <= 1'b1;
                        end
                        if (r_fault && !r_evict) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end
                        r_now      <= r_now + tlbpt_pkg::STAMP_W'(1);
                        r_out_vld  <= 1'b1;
                        r_out_pa   <= pa_ext[tlbpt_pkg::PA_W-1:0];
                        r_out_user <= {r_fault, r_hit};
                        r_state    <= tlbpt_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= tlbpt_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == tlbpt_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_pa;
    assign o_m_tuser  = r_out_user;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_pv)
        else $error("ready while a scan is in flight");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(FRAME_COUNT))
        else $error("frame fill count beyond frame count");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("tlb hit flagged together with page fault");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlbpt_pkg::ST_PLACE && r_evict) |-> !have_free_frame)
        else $error("eviction while a frame is free");

endmodule

[tb/tb_tlb_page_table_translate_lru.sv]
`timescale 1ns / 1ps
// testbench for tlb_page_table_translate_lru: predicts every translation with its own
// tlb, page table and frame ages, and checks hit, fault and physical address per item
// depends on tlbpt_pkg and the block itself

module tb_tlb_page_table_translate_lru;

    localparam int TLB_N   = 64;
    localparam int FRAMES  = 256;
    localparam int OFF_W   = 8;
    localparam int PAGE_W  = 20;
    localparam int SLOW_CY = 2 * TLB_N + FRAMES + 5;
    localparam logic [tlbpt_pkg::AGE_W-1:0] AGE_SAT = '1;

    typedef struct packed {
        logic [tlbpt_pkg::PA_W-1:0] pa;
        logic                       hit;
        logic                       fault;
    } t_xlat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // virtual_address
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // physical_address
    logic [1:0]  o_m_tuser;   // tlb_hit, page_fault

    tlb_page_table_translate_lru i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // predictor state
    logic [PAGE_W-1:0]             tag_page  [TLB_N];
    logic [7:0]                    tag_frame [TLB_N];
    logic                          tag_ok    [TLB_N];
    logic [tlbpt_pkg::AGE_W-1:0]   tag_age   [TLB_N];
    logic [7:0]                    pt_frame  [logic [PAGE_W-1:0]];
    logic                          fr_used   [FRAMES];
    logic [tlbpt_pkg::AGE_W-1:0]   fr_age    [FRAMES];
    logic [PAGE_W-1:0]             fr_owner  [FRAMES];

    t_xlat expected_xlat[$];
    int    mismatches;
    int    xlat_seen;
    int    n_hits, n_faults;
    bit    send_gaps;
    bit    sink_gaps;
    bit    sink_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_oldest_tag();
        int slot;
        logic [tlbpt_pkg::AGE_W-1:0] best;
        slot = 0;
        best = '0;
        for (int e = 0; e < TLB_N; e++)
            if (!tag_ok[e]) return e;
        for (int e = 0; e < TLB_N; e++)
            if (tag_age[e] > best) begin
                best = tag_age[e];
                slot = e;
            end
        return slot;
    endfunction

    function automatic logic [7:0] claim_frame(logic [PAGE_W-1:0] pg);
        int v;
        logic [tlbpt_pkg::AGE_W-1:0] best;
        bit found;
        v = 0;
        best = '0;
        found = 0;
        for (int f = 0; f < FRAMES; f++)
            if (!found && !fr_used[f]) begin
                v = f;
                found = 1;
            end
        if (!found) begin
            for (int f = 0; f < FRAMES; f++)
                if (fr_age[f] > best) begin
                    best = fr_age[f];
                    v = f;
                end
            pt_frame.delete(fr_owner[v]);
            for (int e = 0; e < TLB_N; e++)
                if (tag_ok[e] && tag_frame[e] == v[7:0]) tag_ok[e] = 1'b0;
        end
        fr_used[v] = 1'b1;
        fr_age[v] = '0;
        fr_owner[v] = pg;
        pt_frame[pg] = v[7:0];
        return v[7:0];
    endfunction

    function automatic t_xlat translate(logic [tlbpt_pkg::VA_W-1:0] va);
        t_xlat r;
        logic [PAGE_W-1:0] pg;
        logic [7:0] fr;
        int slot;
        pg = va[OFF_W +: PAGE_W];
        fr = '0;
        r = '0;
        for (int e = 0; e < TLB_N; e++)
            if (tag_ok[e] && tag_page[e] == pg) begin
                fr = tag_frame[e];
                tag_age[e] = '0;
                r.hit = 1'b1;
            end
        if (!r.hit) begin
            if (pt_frame.exists(pg)) fr = pt_frame[pg];
            else begin
                r.fault = 1'b1;
                fr = claim_frame(pg);
            end
            slot = pick_oldest_tag();
            tag_ok[slot] = 1'b1;
            tag_page[slot] = pg;
            tag_frame[slot] = fr;
            tag_age[slot] = '0;
        end
        for (int f = 0; f < FRAMES; f++) if (fr_age[f] != AGE_SAT) fr_age[f]++;
        for (int e = 0; e < TLB_N; e++) if (tag_age[e] != AGE_SAT) tag_age[e]++;
        r.pa = {fr, va[OFF_W-1:0]};
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch item %0d %s: got %0h expected %0h", xlat_seen, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_xlat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_xlat.size() == 0) report_mismatch("unexpected item", 0, 0);
            else begin
                want = expected_xlat.pop_front();
                if (o_m_tdata !== want.pa) report_mismatch("physical_address", o_m_tdata, want.pa);
                if (o_m_tuser[0] !== want.hit) report_mismatch("tlb_hit", o_m_tuser[0], want.hit);
                if (o_m_tuser[1] !== want.fault)
                    report_mismatch("page_fault", o_m_tuser[1], want.fault);
                n_hits += want.hit;
                n_faults += want.fault;
            end
            xlat_seen++;
        end
    end

    // receiver: random bursts of stall, or a long hold
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold) i_m_tready <= 1'b0;
            else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else i_m_tready <= 1'b1;
        end
    end

    // valid stays up after an item until the next item, a gap or a drain replaces it
    task automatic send_va(logic [tlbpt_pkg::VA_W-1:0] va);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'b0, va};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_xlat.push_back(translate(va));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_xlat.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [tlbpt_pkg::VA_W-1:0] mk_va(logic [PAGE_W-1:0] pg);
        return {pg, 8'($urandom)};
    endfunction

    task automatic test_directed();
        send_va('0);
        send_va('0);
        send_va('1);
        send_va('1);
        send_va({20'hFFFFF, 8'h00});
        send_va({20'h00000, 8'hFF});
        send_va(28'h5555555);
        send_va(28'hAAAAAAA);
        send_va(28'h5555500);
        send_va(28'h0000100);
        send_va(28'hAAAAAFF);
        drain();
    endtask

    // many distinct pages overflow the tlb and then all frames, forcing evictions
    task automatic test_eviction();
        for (int i = 0; i < 300; i++) send_va(mk_va(PAGE_W'(i * 7 + 3)));
        for (int i = 0; i < 40; i++) send_va(mk_va(PAGE_W'(i * 7 + 3)));
        drain();
    endtask

    // working set mixes hot tlb pages, table-only pages and new pages
    task automatic test_random(int n);
        logic [PAGE_W-1:0] pg;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pg = PAGE_W'($urandom_range(0, 40));
                4, 5, 6:    pg = PAGE_W'($urandom_range(0, 330));
                7:          pg = PAGE_W'($urandom_range(0, 2000));
                default:    pg = PAGE_W'($urandom);
            endcase
            send_va(mk_va(pg));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (3000) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            test_random(30);
        join
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        mismatches = 0;
        xlat_seen = 0;
        n_hits = 0;
        n_faults = 0;
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        sink_hold = 1'b0;
        for (int e = 0; e < TLB_N; e++) begin
            tag_ok[e] = 1'b0;
            tag_age[e] = '0;
        end
        for (int f = 0; f < FRAMES; f++) begin
            fr_used[f] = 1'b0;
            fr_age[f] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_eviction();
        test_random(500);
        test_backpressure();
        test_random(250);
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        test_random(200);
        drain();
        repeat (SLOW_CY) @(negedge i_clk);
        $display("checked %0d translations: %0d tlb hits, %0d page faults,", xlat_seen,
                 n_hits, n_faults);
        $display("including frame eviction and a long output stall");
        if (mismatches == 0 && expected_xlat.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
hdl/tlbpt_pkg.sv
hdl/tlbpt_age_unit.sv
hdl/tlb_page_table_translate_lru.sv
tb/tb_tlb_page_table_translate_lru.sv
